// ===== rtl/fjs_pkg.sv =====
package fjs_pkg;

  localparam int CHANNEL_W    = 3;
  localparam int CHANNELS_DEF = 7;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [9:0]  US_TO_NS = 10'd1000;
  localparam logic [62:0] MAG_MAX  = {63{1'b1}};
  localparam logic [63:0] MIN_INIT = {64{1'b1}};

  typedef enum logic {
    REQ_RECORD = 1'b0,
    REQ_TAKE   = 1'b1
  } req_kind_t;

  typedef enum logic {
    RES_LOG  = 1'b0,
    RES_SNAP = 1'b1
  } res_kind_t;

  typedef struct packed {
    logic                 req_type;
    logic [CHANNEL_W-1:0] channel;
    logic [63:0]          host_time_ns;
    logic [15:0]          frame_size;
    logic [31:0]          rx_stamp_us;
    logic                 stamp_present;
  } fjs_req_t;

  typedef struct packed {
    logic                 result_kind;
    logic [CHANNEL_W-1:0] result_channel;
    logic [63:0]          elapsed_ns;
    logic [63:0]          host_gap_ns;
    logic [41:0]          stamp_gap_ns;
    logic signed [63:0]   jitter_ns;
    logic [63:0]          frame_count;
    logic [63:0]          byte_count;
    logic [63:0]          gap_min_ns;
    logic [63:0]          gap_max_ns;
    logic [63:0]          gap_sum_ns;
    logic [62:0]          jitter_mag_sum_ns;
  } fjs_result_t;

  // classified transaction as it sits in the queue
  typedef struct packed {
    logic                 take;
    logic [CHANNEL_W-1:0] channel;
    logic                 ch_ok;
    logic [63:0]          elapsed;
    logic [63:0]          host_time;
    logic [15:0]          frame_size;
    logic [31:0]          hw_ts;
    logic                 has_hw;
  } fjs_entry_t;

  typedef struct packed {
    logic       empty;
    fjs_entry_t head;
  } fjs_qstat_t;

  // operation carried down the back pipeline, filled in stage by stage
  typedef struct packed {
    logic                 take;
    logic [CHANNEL_W-1:0] channel;
    logic                 ch_ok;
    logic [63:0]          elapsed;
    logic [15:0]          frame_size;
    logic                 do_int;
    logic                 do_jit;
    logic [63:0]          host_delta;
    logic [31:0]          hw_diff;
    logic [41:0]          hw_delta;
    logic [63:0]          jitter;
    logic [62:0]          mag;
  } fjs_op_t;

endpackage

// ===== rtl/frame_interval_jitter_stats.sv =====
// channel | valid     | stall     | payload
// --------+-----------+-----------+---------------------------------------
// request | req_valid | req_stall | req  (fjs_pkg::fjs_req_t)
// result  | rsp_valid | rsp_stall | rsp  (fjs_pkg::fjs_result_t)
// config  | psel/penable/pwrite, pready=1 | paddr, pwdata, prdata
//
// One transaction per cycle sustained while rsp_stall is low; from acceptance to
// rsp_valid a transaction passes the queue, history lookup at the queue head,
// x1000 multiply, jitter, and commit into the output register.
// Per-channel state sits in flops; all accumulator read-modify-write happens
// in the commit stage, history in stage 1, so same-channel back-to-back
// transactions need no forwarding.
// rst is synchronous; it clears all channel state and start_time_ns at once.
// rsp_stall freezes the whole back pipeline while rsp_valid is high; the
// 4-entry queue keeps accepting until full, then req_stall rises.
module frame_interval_jitter_stats #(
  parameter int CHANNELS = fjs_pkg::CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 req_valid,
  output logic                 req_stall,
  input  fjs_pkg::fjs_req_t    req,

  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output fjs_pkg::fjs_result_t rsp,

  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);
  import fjs_pkg::*;

  // register index sits at paddr[3] (64-bit registers, 8-byte stride)
  localparam logic REG_START_TIME = 1'b0;

  logic [63:0] start_time_ns;
  logic        cfg_wr;

  logic        push;
  logic        q_full;
  logic        pop;
  fjs_entry_t  entry;
  fjs_qstat_t  qs;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  // reads of unmapped addresses return zero
  assign prdata = (paddr[3] == REG_START_TIME) ? start_time_ns : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time_ns <= '0;
    end else if (cfg_wr && paddr[3] == REG_START_TIME) begin
      start_time_ns <= pwdata;
    end
  end

  // front: classify channel, compute elapsed time, enqueue
  fjs_front #(.CHANNELS(CHANNELS)) u_front (
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .start_time_ns (start_time_ns),
    .q_full        (q_full),
    .push          (push),
    .entry         (entry)
  );

  // decoupling queue between front and back
  fjs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .entry (entry),
    .pop   (pop),
    .full  (q_full),
    .qs    (qs)
  );

  // back: stats pipeline and output register
  fjs_back #(.CHANNELS(CHANNELS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .qs        (qs),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== rtl/fjs_front.sv =====
module fjs_front #(
  parameter int CHANNELS = fjs_pkg::CHANNELS_DEF
) (
  input  logic               req_valid,
  output logic               req_stall,
  input  fjs_pkg::fjs_req_t  req,
  input  logic [63:0]        start_time_ns,
  input  logic               q_full,
  output logic               push,
  output fjs_pkg::fjs_entry_t entry
);
  import fjs_pkg::*;

  assign req_stall = q_full;
  assign push      = req_valid && !q_full;

  always_comb begin
    entry            = '0;
    entry.take       = (req.req_type == REQ_TAKE);
    entry.channel    = req.channel;
    entry.ch_ok      = ({{(32 - CHANNEL_W){1'b0}}, req.channel} < 32'(CHANNELS));
    entry.elapsed    = req.host_time_ns - start_time_ns;
    entry.host_time  = req.host_time_ns;
    entry.frame_size = req.frame_size;
    entry.hw_ts      = req.rx_stamp_us;
    entry.has_hw     = req.stamp_present;
  end

endmodule

// ===== rtl/fjs_queue.sv =====
module fjs_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fjs_pkg::fjs_entry_t entry,
  input  logic                pop,
  output logic                full,
  output fjs_pkg::fjs_qstat_t qs
);
  import fjs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  fjs_entry_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(QUEUE_DEPTH));
  assign qs   = {(count == '0), slots[rd_ptr]};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

endmodule

// ===== rtl/fjs_back.sv =====
module fjs_back #(
  parameter int CHANNELS = fjs_pkg::CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fjs_pkg::fjs_qstat_t  qs,
  output logic                 pop,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output fjs_pkg::fjs_result_t rsp
);
  import fjs_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EXT_W = (IDX_W > CHANNEL_W) ? IDX_W : CHANNEL_W;

  // per-channel history, touched in stage 1
  logic [63:0] last_host [CHANNELS];
  logic        host_seen [CHANNELS];
  logic [31:0] last_hw   [CHANNELS];
  logic        hw_seen   [CHANNELS];

  // per-channel accumulators, touched only at commit
  logic [63:0] frames_acc   [CHANNELS];
  logic [63:0] bytes_acc    [CHANNELS];
  logic [63:0] min_interval [CHANNELS];
  logic [63:0] max_interval [CHANNELS];
  logic [63:0] sum_interval [CHANNELS];
  logic [62:0] abs_jit_acc  [CHANNELS];
  logic [62:0] max_abs_jit  [CHANNELS];

  fjs_op_t p1, p2, p3;
  fjs_op_t p1_next, p2_next, p3_next;
  logic    p1_valid, p2_valid, p3_valid;
  logic    adv;

  logic [EXT_W-1:0] ch1_ext, ch3_ext;
  logic [IDX_W-1:0] idx1, idx3;

  logic [63:0] diff, ndiff;

  logic [63:0] frames_rd, bytes_rd, min_rd, max_rd, sum_rd;
  logic [62:0] abs_rd, maxabs_rd;
  logic [63:0] frames_next, bytes_next, min_next, max_next, sum_next;
  logic [62:0] abs_next, maxabs_next;
  fjs_result_t res;

  assign adv = !rsp_valid || !rsp_stall;
  assign pop = adv && !qs.empty;

  assign ch1_ext = EXT_W'(qs.head.channel);
  assign idx1    = ch1_ext[IDX_W-1:0];
  assign ch3_ext = EXT_W'(p3.channel);
  assign idx3    = ch3_ext[IDX_W-1:0];

  // stage 1: history lookup, host interval, raw timestamp difference
  always_comb begin
    p1_next            = '0;
    p1_next.take       = qs.head.take;
    p1_next.channel    = qs.head.channel;
    p1_next.ch_ok      = qs.head.ch_ok;
    p1_next.elapsed    = qs.head.elapsed;
    p1_next.frame_size = qs.head.frame_size;
    if (qs.head.ch_ok && !qs.head.take) begin
      p1_next.do_int = host_seen[idx1];
      p1_next.do_jit = host_seen[idx1] && hw_seen[idx1] && qs.head.has_hw;
      if (host_seen[idx1]) begin
        p1_next.host_delta = qs.head.host_time - last_host[idx1];
      end
      p1_next.hw_diff = qs.head.hw_ts - last_hw[idx1];
    end
  end

  // stage 2: microsecond delta to nanoseconds
  always_comb begin
    p2_next = p1;
    p2_next.hw_delta = p1.do_jit ? 42'(p1.hw_diff) * 42'(US_TO_NS) : '0;
  end

  // stage 3: signed jitter and its saturated magnitude
  assign diff  = p2.host_delta - {22'b0, p2.hw_delta};
  assign ndiff = {22'b0, p2.hw_delta} - p2.host_delta;

  always_comb begin
    p3_next = p2;
    p3_next.jitter = '0;
    p3_next.mag    = '0;
    if (p2.do_jit) begin
      p3_next.jitter = diff;
      if (!diff[63]) begin
        p3_next.mag = diff[62:0];
      end else if (ndiff[63]) begin
        p3_next.mag = MAG_MAX;
      end else begin
        p3_next.mag = ndiff[62:0];
      end
    end
  end

  // commit: accumulator update and result build
  always_comb begin
    frames_rd = '0;
    bytes_rd  = '0;
    min_rd    = MIN_INIT;
    max_rd    = '0;
    sum_rd    = '0;
    abs_rd    = '0;
    maxabs_rd = '0;
    if (p3.ch_ok) begin
      frames_rd = frames_acc[idx3];
      bytes_rd  = bytes_acc[idx3];
      min_rd    = min_interval[idx3];
      max_rd    = max_interval[idx3];
      sum_rd    = sum_interval[idx3];
      abs_rd    = abs_jit_acc[idx3];
      maxabs_rd = max_abs_jit[idx3];
    end

    frames_next = frames_rd + 64'd1;
    bytes_next  = bytes_rd + {48'b0, p3.frame_size};
    min_next    = min_rd;
    max_next    = max_rd;
    sum_next    = sum_rd;
    abs_next    = abs_rd;
    maxabs_next = maxabs_rd;
    if (p3.do_int) begin
      sum_next = sum_rd + p3.host_delta;
      if (p3.host_delta < min_rd) begin
        min_next = p3.host_delta;
      end
      if (p3.host_delta > max_rd) begin
        max_next = p3.host_delta;
      end
    end
    if (p3.do_jit) begin
      abs_next = abs_rd + p3.mag;
      if (p3.mag > maxabs_rd) begin
        maxabs_next = p3.mag;
      end
    end

    res                = '0;
    res.result_channel = p3.channel;
    if (p3.take) begin
      res.result_kind       = RES_SNAP;
      res.jitter_ns         = {1'b0, maxabs_rd};
      res.frame_count       = frames_rd;
      res.byte_count        = bytes_rd;
      res.gap_min_ns        = min_rd;
      res.gap_max_ns        = max_rd;
      res.gap_sum_ns        = sum_rd;
      res.jitter_mag_sum_ns = abs_rd;
    end else begin
      res.result_kind  = RES_LOG;
      res.elapsed_ns   = p3.elapsed;
      res.host_gap_ns  = p3.host_delta;
      res.stamp_gap_ns = p3.hw_delta;
      res.jitter_ns    = p3.jitter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        last_host[c]    <= '0;
        host_seen[c]    <= 1'b0;
        last_hw[c]      <= '0;
        hw_seen[c]      <= 1'b0;
        frames_acc[c]   <= '0;
        bytes_acc[c]    <= '0;
        min_interval[c] <= MIN_INIT;
        max_interval[c] <= '0;
        sum_interval[c] <= '0;
        abs_jit_acc[c]  <= '0;
        max_abs_jit[c]  <= '0;
      end
    end else if (adv) begin
      p1_valid  <= pop;
      p2_valid  <= p1_valid;
      p3_valid  <= p2_valid;
      rsp_valid <= p3_valid;
      if (pop && qs.head.ch_ok && !qs.head.take) begin
        last_host[idx1] <= qs.head.host_time;
        host_seen[idx1] <= 1'b1;
        if (qs.head.has_hw) begin
          last_hw[idx1] <= qs.head.hw_ts;
          hw_seen[idx1] <= 1'b1;
        end
      end
      if (p3_valid && p3.ch_ok) begin
        if (p3.take) begin
          frames_acc[idx3]   <= '0;
          bytes_acc[idx3]    <= '0;
          min_interval[idx3] <= MIN_INIT;
          max_interval[idx3] <= '0;
          sum_interval[idx3] <= '0;
          abs_jit_acc[idx3]  <= '0;
          max_abs_jit[idx3]  <= '0;
        end else begin
          frames_acc[idx3]   <= frames_next;
          bytes_acc[idx3]    <= bytes_next;
          min_interval[idx3] <= min_next;
          max_interval[idx3] <= max_next;
          sum_interval[idx3] <= sum_next;
          abs_jit_acc[idx3]  <= abs_next;
          max_abs_jit[idx3]  <= maxabs_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1  <= p1_next;
      p2  <= p2_next;
      p3  <= p3_next;
      rsp <= res;
    end
  end

  a_snap_no_log_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.result_kind == RES_SNAP |->
      rsp.elapsed_ns == '0 && rsp.host_gap_ns == '0 && rsp.stamp_gap_ns == '0)
    else $error("snapshot carries log fields");

  a_jitter_matches: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.result_kind == RES_LOG && rsp.stamp_gap_ns != '0 |->
      rsp.jitter_ns == $signed(rsp.host_gap_ns - {22'b0, rsp.stamp_gap_ns}))
    else $error("log jitter disagrees with deltas");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.result_kind == RES_SNAP && rsp.gap_max_ns != '0 |->
      rsp.gap_min_ns <= rsp.gap_max_ns)
    else $error("snapshot min interval above max");

  a_snap_jitter_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.result_kind == RES_SNAP |-> !rsp.jitter_ns[63])
    else $error("snapshot max jitter negative");

endmodule
